@@ rtl/mmf_pkg.sv @@
// ----------------------------------------------------------------------------
// mmf_pkg
// Shared constants and types of the MIDI message filter.
// ----------------------------------------------------------------------------
package mmf_pkg;

    localparam int STORE_DEPTH  = 64;
    localparam int ADDR_W       = 6;
    localparam int CNT_W        = 7;
    localparam int SYSEX_MAX_DEF = 64;

    localparam logic [7:0] ST_SYSEX     = 8'hF0;
    localparam logic [7:0] ST_EOX       = 8'hF7;
    localparam logic [7:0] ST_MTC       = 8'hF1;
    localparam logic [7:0] ST_SONG_POS  = 8'hF2;
    localparam logic [7:0] ST_SONG_SEL  = 8'hF3;
    localparam logic [7:0] ST_CLOCK     = 8'hF8;
    localparam logic [7:0] ST_START     = 8'hFA;
    localparam logic [7:0] ST_STOP      = 8'hFC;

    localparam logic [3:0] HI_NOTE_OFF  = 4'h8;
    localparam logic [3:0] HI_NOTE_ON   = 4'h9;
    localparam logic [3:0] HI_CTRL      = 4'hB;
    localparam logic [3:0] HI_PROG      = 4'hC;
    localparam logic [3:0] HI_SYSTEM    = 4'hF;

    localparam logic [1:0] TIMING_NONE  = 2'd0;
    localparam logic [1:0] TIMING_CLOCK = 2'd1;
    localparam logic [1:0] TIMING_START = 2'd2;
    localparam logic [1:0] TIMING_STOP  = 2'd3;

    localparam logic [1:0] LEN_NONE  = 2'd0;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef struct packed {
        logic             valid;
        logic             single;
        logic [CNT_W-1:0] len;
        logic             note_on;
        logic [7:0]       data;
        logic [7:0]       key;
        logic [7:0]       vel;
        logic [1:0]       timing;
    } t_emit_req;

endpackage

@@ rtl/midi_message_filter.sv @@
// ----------------------------------------------------------------------------
// midi_message_filter
// Byte-serial MIDI filter that forwards complete messages as byte runs.
// ----------------------------------------------------------------------------
// Received MIDI bytes enter on the s_axis channel, one byte per transaction.
// Bytes of a message in progress are written to a 64-entry message store.
// When a message completes, it leaves on the m_axis channel as a run of
// transactions, one byte each, with tlast on its final byte. The note on
// flag, key and velocity ride on the final byte of a note on, and realtime
// clock, start and stop bytes leave at once with a timing code in tuser.
// A byte that does not complete a message leaves the input ready for the next
// byte. A byte that completes a message is followed by its readout: the
// request is registered and handed over, then each byte is read from the store,
// loaded and output, and the next byte is taken only when the readout is done.
// A clock, start or stop byte skips the store: its transaction goes from the
// request register straight into the output register, and the next byte is
// taken once it has left. The store's single read port paces the readout.
// While the receiver holds m_axis_tready low, the output register holds its
// transaction and no new input byte is taken. Synchronous reset returns the
// parser to idle and empties the output register; the store keeps its
// contents, and no entry is read before it is written.
// ----------------------------------------------------------------------------
module midi_message_filter #(
    parameter int SYSEX_MAX = mmf_pkg::SYSEX_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] out_byte, [15:8] note_key,
                                        // [23:16] note_velocity
    output logic        m_axis_tlast,
    output logic [2:0]  m_axis_tuser    // [0] note_on_event, [2:1] timing_event
);

    mmf_pkg::t_emit_req        req;
    logic                      busy;
    logic                      wr_en;
    logic [mmf_pkg::ADDR_W-1:0] wr_addr;
    logic [7:0]                wr_data;
    logic [mmf_pkg::ADDR_W-1:0] rd_addr;
    logic [7:0]                rd_data;
    logic [7:0]                out_byte;
    logic                      note_on;
    logic [7:0]                note_key;
    logic [7:0]                note_vel;
    logic [1:0]                timing;

    mmf_collect #(
        .SYSEX_MAX(SYSEX_MAX)
    ) u_collect (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_data   (s_axis_tdata),
        .i_busy   (busy),
        .o_req    (req),
        .o_wr_en  (wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data)
    );

    mmf_ram #(
        .WIDTH(8),
        .DEPTH(mmf_pkg::STORE_DEPTH)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    mmf_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (req),
        .o_busy   (busy),
        .o_rd_addr(rd_addr),
        .i_rd_data(rd_data),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_data   (out_byte),
        .o_last   (m_axis_tlast),
        .o_note_on(note_on),
        .o_key    (note_key),
        .o_vel    (note_vel),
        .o_timing (timing)
    );

    assign m_axis_tdata = {note_vel, note_key, out_byte};
    assign m_axis_tuser = {timing, note_on};

    a_no_input_during_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> !s_axis_tready)
        else $error("input taken during message readout");

    a_output_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> busy)
        else $error("output valid while readout idle");

    a_note_on_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tlast)
        else $error("note on flag away from final byte");

    a_timing_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser[2:1] != mmf_pkg::TIMING_NONE))
            |-> (m_axis_tlast && !m_axis_tuser[0]))
        else $error("timing event on a multi-byte message");

endmodule

@@ rtl/mmf_ram.sv @@
// ----------------------------------------------------------------------------
// mmf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/mmf_collect.sv @@
// ----------------------------------------------------------------------------
// mmf_collect
// Parses incoming bytes, writes message bytes to the store and requests
// readout of each complete message.
// ----------------------------------------------------------------------------
module mmf_collect #(
    parameter int SYSEX_MAX = mmf_pkg::SYSEX_MAX_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_data,
    input  logic                       i_busy,
    output mmf_pkg::t_emit_req         o_req,
    output logic                       o_wr_en,
    output logic [mmf_pkg::ADDR_W-1:0] o_wr_addr,
    output logic [7:0]                 o_wr_data
);

    localparam int LIMIT_I = (SYSEX_MAX > mmf_pkg::STORE_DEPTH) ?
                             mmf_pkg::STORE_DEPTH : SYSEX_MAX;
    localparam logic [mmf_pkg::CNT_W-1:0] LIMIT = mmf_pkg::CNT_W'(LIMIT_I);

    logic [mmf_pkg::CNT_W-1:0] r_count, n_count;
    logic [1:0]                r_exp, n_exp;
    logic                      r_sysex, n_sysex;
    logic                      r_note, n_note;
    logic [7:0]                r_key, n_key;
    mmf_pkg::t_emit_req        r_req, n_req;
    logic                      accept;
    logic [mmf_pkg::CNT_W-1:0] next_len;
    logic [3:0]                hi;

    assign o_ready  = !r_req.valid && !i_busy;
    assign accept   = i_valid && o_ready;
    assign next_len = r_count + mmf_pkg::CNT_W'(1);
    assign hi       = i_data[7:4];
    assign o_req    = r_req;

    always_comb begin
        n_count   = r_count;
        n_exp     = r_exp;
        n_sysex   = r_sysex;
        n_note    = r_note;
        n_key     = r_key;
        n_req     = '0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_count[mmf_pkg::ADDR_W-1:0];
        o_wr_data = i_data;
        if (accept) begin
            if (r_sysex) begin
                if (i_data == mmf_pkg::ST_EOX) begin
                    n_req.valid = 1'b1;
                    n_req.len   = r_count;
                    n_count     = '0;
                    n_sysex     = 1'b0;
                end else if (r_count >= LIMIT) begin
                    n_count = '0;
                    n_sysex = 1'b0;
                end else begin
                    o_wr_en = 1'b1;
                    n_count = next_len;
                end
            end else if (r_count != '0) begin
                o_wr_en = 1'b1;
                if (r_count == mmf_pkg::CNT_W'(1)) begin
                    n_key = i_data;
                end
                if (next_len >= mmf_pkg::CNT_W'(r_exp)) begin
                    n_req.valid   = 1'b1;
                    n_req.len     = next_len;
                    n_req.note_on = r_note;
                    n_req.key     = (r_count == mmf_pkg::CNT_W'(1)) ? i_data : r_key;
                    n_req.vel     = i_data;
                    n_count       = '0;
                    n_exp         = mmf_pkg::LEN_NONE;
                end else begin
                    n_count = next_len;
                end
            end else begin
                o_wr_addr = '0;
                n_note    = (hi == mmf_pkg::HI_NOTE_ON);
                case (hi)
                    mmf_pkg::HI_NOTE_OFF, mmf_pkg::HI_NOTE_ON, mmf_pkg::HI_CTRL: begin
                        o_wr_en = 1'b1;
                        n_count = mmf_pkg::CNT_W'(1);
                        n_exp   = mmf_pkg::LEN_THREE;
                    end
                    mmf_pkg::HI_PROG: begin
                        o_wr_en = 1'b1;
                        n_count = mmf_pkg::CNT_W'(1);
                        n_exp   = mmf_pkg::LEN_TWO;
                    end
                    mmf_pkg::HI_SYSTEM: begin
                        case (i_data)
                            mmf_pkg::ST_SYSEX: begin
                                o_wr_en = 1'b1;
                                n_count = mmf_pkg::CNT_W'(1);
                                n_sysex = 1'b1;
                            end
                            mmf_pkg::ST_MTC, mmf_pkg::ST_SONG_SEL: begin
                                o_wr_en = 1'b1;
                                n_count = mmf_pkg::CNT_W'(1);
                                n_exp   = mmf_pkg::LEN_TWO;
                            end
                            mmf_pkg::ST_SONG_POS: begin
                                o_wr_en = 1'b1;
                                n_count = mmf_pkg::CNT_W'(1);
                                n_exp   = mmf_pkg::LEN_THREE;
                            end
                            mmf_pkg::ST_CLOCK: begin
                                n_req.valid  = 1'b1;
                                n_req.single = 1'b1;
                                n_req.len    = mmf_pkg::CNT_W'(1);
                                n_req.data   = i_data;
                                n_req.timing = mmf_pkg::TIMING_CLOCK;
                            end
                            mmf_pkg::ST_START: begin
                                n_req.valid  = 1'b1;
                                n_req.single = 1'b1;
                                n_req.len    = mmf_pkg::CNT_W'(1);
                                n_req.data   = i_data;
                                n_req.timing = mmf_pkg::TIMING_START;
                            end
                            mmf_pkg::ST_STOP: begin
                                n_req.valid  = 1'b1;
                                n_req.single = 1'b1;
                                n_req.len    = mmf_pkg::CNT_W'(1);
                                n_req.data   = i_data;
                                n_req.timing = mmf_pkg::TIMING_STOP;
                            end
                            default: begin
                            end
                        endcase
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_exp   <= mmf_pkg::LEN_NONE;
            r_sysex <= 1'b0;
            r_req   <= '0;
        end else begin
            r_count <= n_count;
            r_exp   <= n_exp;
            r_sysex <= n_sysex;
            r_req   <= n_req;
        end
        r_note <= n_note;
        r_key  <= n_key;
    end

endmodule

@@ rtl/mmf_emit.sv @@
// ----------------------------------------------------------------------------
// mmf_emit
// Reads a finished message out of the store and drives the output register.
// ----------------------------------------------------------------------------
module mmf_emit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  mmf_pkg::t_emit_req         i_req,
    output logic                       o_busy,
    output logic [mmf_pkg::ADDR_W-1:0] o_rd_addr,
    input  logic [7:0]                 i_rd_data,
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [7:0]                 o_data,
    output logic                       o_last,
    output logic                       o_note_on,
    output logic [7:0]                 o_key,
    output logic [7:0]                 o_vel,
    output logic [1:0]                 o_timing
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_OUT
    } t_state;

    t_state                    r_state;
    logic [mmf_pkg::CNT_W-1:0] r_idx;
    logic [mmf_pkg::CNT_W-1:0] r_len;
    logic                      r_note;
    logic [7:0]                r_key;
    logic [7:0]                r_vel;
    logic                      r_valid;
    logic [7:0]                r_data;
    logic                      r_last;
    logic                      r_note_on;
    logic [7:0]                r_key_out;
    logic [7:0]                r_vel_out;
    logic [1:0]                r_timing;
    logic                      is_last;

    assign is_last   = (r_idx == r_len - mmf_pkg::CNT_W'(1));
    assign o_busy    = (r_state != S_IDLE);
    assign o_rd_addr = r_idx[mmf_pkg::ADDR_W-1:0];
    assign o_valid   = r_valid;
    assign o_data    = r_data;
    assign o_last    = r_last;
    assign o_note_on = r_note_on;
    assign o_key     = r_key_out;
    assign o_vel     = r_vel_out;
    assign o_timing  = r_timing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_idx  <= '0;
                        r_len  <= i_req.len;
                        r_note <= i_req.note_on;
                        r_key  <= i_req.key;
                        r_vel  <= i_req.vel;
                        if (i_req.single) begin
                            r_data    <= i_req.data;
                            r_last    <= 1'b1;
                            r_note_on <= 1'b0;
                            r_key_out <= '0;
                            r_vel_out <= '0;
                            r_timing  <= i_req.timing;
                            r_valid   <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_data    <= i_rd_data;
                    r_last    <= is_last;
                    r_note_on <= is_last && r_note;
                    r_key_out <= (is_last && r_note) ? r_key : 8'd0;
                    r_vel_out <= (is_last && r_note) ? r_vel : 8'd0;
                    r_timing  <= mmf_pkg::TIMING_NONE;
                    r_valid   <= 1'b1;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx   <= r_idx + mmf_pkg::CNT_W'(1);
                            r_state <= S_READ;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ tb/sv/midi_message_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_message_checker
// Watches both stream channels of the MIDI message filter and scores results.
// ----------------------------------------------------------------------------
// Every input transaction is run through a byte-level model of the MIDI
// parser. The forwarded bytes it predicts are queued in order. Every output
// transaction is compared field by field with the oldest queued byte. The
// failure count and the number of bytes still awaited go to the testbench top.
// ----------------------------------------------------------------------------
module midi_message_checker
    import mmf_pkg::*;
#(
    parameter int SYSEX_MAX = SYSEX_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // [7:0] data_byte
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,   // [7:0] out_byte, [15:8] note_key,
                                      // [23:16] note_velocity
    input  logic        i_out_last,
    input  logic [2:0]  i_out_user,   // [0] note_on_event, [2:1] timing_event
    output int          o_fail_count,
    output int          o_pending
);

    localparam int SYSEX_LIMIT = (SYSEX_MAX > STORE_DEPTH) ? STORE_DEPTH : SYSEX_MAX;

    typedef struct packed {
        logic [7:0] midi_byte;
        logic       last;
        logic       note_on;
        logic [7:0] key;
        logic [7:0] vel;
        logic [1:0] timing;
    } t_fwd_byte;

    logic [CNT_W-1:0] collect_cnt;
    logic [1:0]       msg_len;
    logic             sysex_open;
    logic [7:0]       msg_buf [STORE_DEPTH];
    t_fwd_byte        expected_fwd [$];
    int               fail_cnt = 0;

    task automatic return_to_idle();
        collect_cnt = '0;
        msg_len     = LEN_NONE;
        sysex_open  = 1'b0;
    endtask

    task automatic queue_message(input int len, input logic note_on);
        t_fwd_byte r;
        for (int k = 0; k < len; k++) begin
            r           = '0;
            r.midi_byte = msg_buf[k];
            r.last      = (k == len - 1);
            if (r.last && note_on) begin
                r.note_on = 1'b1;
                r.key     = msg_buf[1];
                r.vel     = msg_buf[2];
            end
            expected_fwd.push_back(r);
        end
    endtask

    task automatic queue_realtime(input logic [7:0] b, input logic [1:0] code);
        t_fwd_byte r;
        r           = '0;
        r.midi_byte = b;
        r.last      = 1'b1;
        r.timing    = code;
        expected_fwd.push_back(r);
    endtask

    task automatic predict_byte(input logic [7:0] b);
        logic [1:0] need;
        need = LEN_NONE;
        if (sysex_open) begin
            if (b == ST_EOX) begin
                queue_message(int'(collect_cnt), 1'b0);
                return_to_idle();
            end else if (collect_cnt >= SYSEX_LIMIT) begin
                // An overlong sysex is thrown away together with this byte.
                return_to_idle();
            end else begin
                msg_buf[collect_cnt[ADDR_W-1:0]] = b;
                collect_cnt = collect_cnt + 1'b1;
            end
        end else if (collect_cnt != 0) begin
            msg_buf[collect_cnt[ADDR_W-1:0]] = b;
            if (int'(collect_cnt) + 1 >= int'(msg_len)) begin
                queue_message(int'(collect_cnt) + 1, msg_buf[0][7:4] == HI_NOTE_ON);
                return_to_idle();
            end else begin
                collect_cnt = collect_cnt + 1'b1;
            end
        end else begin
            case (b[7:4])
                HI_NOTE_OFF, HI_NOTE_ON, HI_CTRL: need = LEN_THREE;
                HI_PROG: need = LEN_TWO;
                HI_SYSTEM: begin
                    case (b)
                        ST_SYSEX: begin
                            msg_buf[0]  = b;
                            collect_cnt = CNT_W'(1);
                            sysex_open  = 1'b1;
                        end
                        ST_MTC, ST_SONG_SEL: need = LEN_TWO;
                        ST_SONG_POS: need = LEN_THREE;
                        ST_CLOCK: queue_realtime(b, TIMING_CLOCK);
                        ST_START: queue_realtime(b, TIMING_START);
                        ST_STOP: queue_realtime(b, TIMING_STOP);
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (need != LEN_NONE) begin
                msg_buf[0]  = b;
                collect_cnt = CNT_W'(1);
                msg_len     = need;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_fwd_byte got;
        t_fwd_byte want;
        if (!i_rst_n) begin
            return_to_idle();
            foreach (msg_buf[i]) msg_buf[i] = '0;
            expected_fwd.delete();
        end else begin
            if (i_in_valid && i_in_ready) begin
                predict_byte(i_in_data);
            end
            if (i_out_valid && i_out_ready) begin
                got.midi_byte = i_out_data[7:0];
                got.key       = i_out_data[15:8];
                got.vel       = i_out_data[23:16];
                got.last      = i_out_last;
                got.note_on   = i_out_user[0];
                got.timing    = i_out_user[2:1];
                if (expected_fwd.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= 10) begin
                        $display("%0t: unexpected byte %h last %b note %b key %h vel %h tm %0d",
                                 $time, got.midi_byte, got.last, got.note_on, got.key,
                                 got.vel, got.timing);
                    end
                end else begin
                    want = expected_fwd.pop_front();
                    if (got.midi_byte !== want.midi_byte || got.last !== want.last ||
                        got.note_on !== want.note_on || got.key !== want.key ||
                        got.vel !== want.vel || got.timing !== want.timing) begin
                        fail_cnt++;
                        if (fail_cnt <= 10) begin
                            $display("%0t: expected %h last %b note %b key %h vel %h tm %0d",
                                     $time, want.midi_byte, want.last, want.note_on,
                                     want.key, want.vel, want.timing);
                            $display("%0t:   actual %h last %b note %b key %h vel %h tm %0d",
                                     $time, got.midi_byte, got.last, got.note_on, got.key,
                                     got.vel, got.timing);
                        end
                    end
                end
            end
        end
        o_fail_count = fail_cnt;
        o_pending    = expected_fwd.size();
    end

endmodule

@@ tb/sv/tb_midi_message_filter.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_midi_message_filter
// Stimulus and verdict for the MIDI message filter.
// ----------------------------------------------------------------------------
// A short directed byte sequence covers every message kind, realtime bytes,
// stray and unused status bytes and the empty sysex. It is followed by random
// well-formed messages with random content, mixed with noise bytes, including
// the longest sysex and an overlong one. Both sides idle at random, and the
// receiver holds off once for a long stretch so the filter stalls its input.
// The checker instance predicts and compares every output transaction.
// ----------------------------------------------------------------------------
module tb_midi_message_filter;
    import mmf_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MSG_ITEMS   = 480;
    localparam int HOLD_START  = 200;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_WAIT  = 300;

    localparam logic [3:0] HI_POLY_PRESS   = 4'hA;
    localparam logic [3:0] HI_CHAN_PRESS   = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND   = 4'hE;
    localparam logic [7:0] ST_SYSTEM_RESET = 8'hFF;

    localparam int OPENING_LEN = 29;
    localparam logic [7:0] OPENING [OPENING_LEN] = '{
        {HI_NOTE_ON, 4'hF}, 8'h7F, 8'hFF,
        {HI_NOTE_OFF, 4'h0}, ST_CLOCK, 8'h00,
        {HI_CTRL, 4'h3}, 8'h40, {HI_NOTE_ON, 4'h0},
        {HI_PROG, 4'hF}, 8'h00,
        ST_MTC, 8'h7F,
        ST_SONG_SEL, ST_SYSEX,
        ST_SONG_POS, 8'h01, 8'h02,
        ST_CLOCK, ST_START, ST_STOP,
        8'h00, {HI_POLY_PRESS, 4'h5}, {HI_CHAN_PRESS, 4'h0}, {HI_PITCH_BEND, 4'hF},
        ST_EOX, ST_SYSTEM_RESET,
        ST_SYSEX, ST_EOX
    };

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_data;
    logic        m_last;
    logic [2:0]  m_user;
    logic        rx_hold = 1'b0;
    logic        no_idle = 1'b0;
    int          msg_items   = 0;
    int          rx_stall    = 0;
    int          cycle_count = 0;
    int          fail_count;
    int          pending;

    midi_message_filter dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .s_axis_tdata  (s_data),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready),
        .m_axis_tdata  (m_data),
        .m_axis_tlast  (m_last),
        .m_axis_tuser  (m_user)
    );

    midi_message_checker u_msg_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (s_valid),
        .i_in_ready   (s_ready),
        .i_in_data    (s_data),
        .i_out_valid  (m_valid),
        .i_out_ready  (m_ready),
        .i_out_data   (m_data),
        .i_out_last   (m_last),
        .i_out_user   (m_user),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_midi_message_filter: done, errors");
            $finish;
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 16));
    endfunction

    function automatic logic [7:0] msg_data();
        return ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 127));
    endfunction

    always @(posedge clk) begin
        int n;
        if (!rst_n) begin
            m_ready  <= 1'b0;
            rx_stall <= 0;
        end else if (m_valid && m_ready) begin
            n = draw_gap();
            rx_stall <= n;
            m_ready  <= (n == 0) && !rx_hold;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready  <= (rx_stall == 1) && !rx_hold;
        end else begin
            m_ready <= !rx_hold;
        end
    end

    initial begin
        wait (msg_items >= HOLD_START);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    task automatic offer_byte(input logic [7:0] b);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge clk);
        while (!s_ready) @(posedge clk);
    endtask

    task automatic send_counted(input logic [7:0] b);
        offer_byte(b);
        msg_items++;
    endtask

    task automatic send_short(input logic [7:0] head, input int len);
        send_counted(head);
        repeat (len - 1) send_counted(msg_data());
    endtask

    task automatic send_sysex(input int n);
        send_counted(ST_SYSEX);
        repeat (n) send_counted(msg_data());
        send_counted(ST_EOX);
    endtask

    task automatic send_random_message();
        logic [3:0] ch;
        int         pick;
        int         n;
        ch = 4'($urandom_range(0, 15));
        case ($urandom_range(0, 8))
            0: send_short({HI_NOTE_OFF, ch}, 3);
            1, 2: send_short({HI_NOTE_ON, ch}, 3);
            3: send_short({HI_CTRL, ch}, 3);
            4: send_short({HI_PROG, ch}, 2);
            5: send_short($urandom_range(0, 1) ? ST_MTC : ST_SONG_SEL, 2);
            6: send_short(ST_SONG_POS, 3);
            7: begin
                case ($urandom_range(0, 2))
                    0: send_counted(ST_CLOCK);
                    1: send_counted(ST_START);
                    default: send_counted(ST_STOP);
                endcase
            end
            default: begin
                pick = $urandom_range(0, 39);
                if (pick == 0) begin
                    n = $urandom_range(STORE_DEPTH, STORE_DEPTH + 6);
                end else if (pick < 4) begin
                    n = $urandom_range(16, STORE_DEPTH - 1);
                end else begin
                    n = $urandom_range(0, 8);
                end
                send_sysex(n);
            end
        endcase
    endtask

    initial begin
        int seg_left;
        seg_left = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < OPENING_LEN; i++) send_counted(OPENING[i]);

        // Longest sysex that fits, then one byte too long.
        send_sysex(STORE_DEPTH - 1);
        send_sysex(STORE_DEPTH);

        while (msg_items < MSG_ITEMS) begin
            if (seg_left == 0) begin
                no_idle  <= ($urandom_range(0, 3) == 0);
                seg_left = 25;
            end
            seg_left--;
            if ($urandom_range(0, 5) == 0) begin
                send_counted(8'($urandom_range(0, 255)));
            end else begin
                send_random_message();
            end
        end
        s_valid <= 1'b0;

        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("tb_midi_message_filter: done, clean");
        end else begin
            $display("tb_midi_message_filter: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/mmf_pkg.sv
rtl/mmf_ram.sv
rtl/mmf_collect.sv
rtl/mmf_emit.sv
rtl/midi_message_filter.sv
tb/sv/midi_message_checker.sv
tb/sv/tb_midi_message_filter.sv
